@@ rtl/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants and types for the comment stripper: character codes and
// the per-byte step result handed from the lexer to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

    // Character codes
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_SPACE  = 8'd32;

    // Output queue
    localparam int unsigned QUEUE_DEPTH = 4;

    // Result words produced by one input byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] ch0;
        logic       last0;
        logic [7:0] ch1;
        logic       last1;
    } ccs_step_t;

endpackage

`default_nettype wire

@@ rtl/ccs_lexer.sv @@
// ----------------------------------------------------------------------------
// ccs_lexer
// Lexer state machine. For each accepted byte it decides combinationally which
// words go out and updates the lexer state and the directive-line flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_lexer
    import ccs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output ccs_step_t       result
);

    typedef enum logic [3:0] {
        ST_NORMAL   = 4'd0,
        ST_SLASH    = 4'd1,
        ST_BLOCK    = 4'd2,
        ST_BLOCK_ST = 4'd3,
        ST_LINE     = 4'd4,
        ST_LINE_BS  = 4'd5,
        ST_DQ       = 4'd6,
        ST_DQ_ESC   = 4'd7,
        ST_SQ       = 4'd8,
        ST_SQ_ESC   = 4'd9
    } state_t;

    state_t state_reg, state_next;
    logic   dir_reg, dir_next;

    // Plain-text handling of the current byte
    state_t plain_state;
    logic   plain_dir;
    logic   plain_emit;

    always_comb begin
        plain_state = ST_NORMAL;
        plain_dir   = dir_reg;
        plain_emit  = 1'b1;
        if (ch == CH_SLASH) begin
            plain_state = ST_SLASH;
            plain_emit  = 1'b0;
        end else if (ch == CH_DQUOTE) begin
            plain_state = ST_DQ;
        end else if (ch == CH_SQUOTE) begin
            plain_state = ST_SQ;
        end else if (ch == CH_HASH) begin
            plain_dir = 1'b1;
        end else if (ch == CH_NL) begin
            plain_dir = 1'b0;
        end
    end

    // Next state and emitted words
    always_comb begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        result.count = 2'd0;
        result.ch0   = ch;
        result.ch1   = ch;
        result.last0 = 1'b0;
        result.last1 = 1'b0;

        unique case (state_reg)
            ST_SLASH: begin
                if (ch == CH_STAR) begin
                    state_next = ST_BLOCK;
                    if (dir_reg) begin
                        result.count = 2'd1;
                        result.ch0   = CH_SPACE;
                    end
                end else if (ch == CH_SLASH) begin
                    state_next = ST_LINE;
                end else begin
                    // emit the held slash, then the byte as plain text
                    result.count = 2'd2;
                    result.ch0   = CH_SLASH;
                    state_next   = plain_state;
                    dir_next     = plain_dir;
                end
            end
            ST_BLOCK: begin
                if (ch == CH_STAR) begin
                    state_next = ST_BLOCK_ST;
                end
            end
            ST_BLOCK_ST: begin
                if (ch == CH_SLASH) begin
                    state_next = ST_NORMAL;
                end else if (ch != CH_STAR) begin
                    state_next = ST_BLOCK;
                end
            end
            ST_LINE: begin
                if (ch == CH_NL) begin
                    result.count = 2'd1;
                    state_next   = ST_NORMAL;
                    dir_next     = 1'b0;
                end else if (ch == CH_BSLASH) begin
                    state_next = ST_LINE_BS;
                end
            end
            ST_LINE_BS: begin
                if (ch != CH_BSLASH) begin
                    state_next = ST_LINE;
                end
            end
            ST_DQ: begin
                result.count = 2'd1;
                if (ch == CH_BSLASH) begin
                    state_next = ST_DQ_ESC;
                end else if (ch == CH_DQUOTE) begin
                    state_next = ST_NORMAL;
                end else if (ch == CH_NL) begin
                    state_next = ST_NORMAL;
                    dir_next   = 1'b0;
                end
            end
            ST_DQ_ESC: begin
                result.count = 2'd1;
                state_next   = ST_DQ;
            end
            ST_SQ: begin
                result.count = 2'd1;
                if (ch == CH_BSLASH) begin
                    state_next = ST_SQ_ESC;
                end else if (ch == CH_SQUOTE) begin
                    state_next = ST_NORMAL;
                end else if (ch == CH_NL) begin
                    state_next = ST_NORMAL;
                    dir_next   = 1'b0;
                end
            end
            ST_SQ_ESC: begin
                result.count = 2'd1;
                state_next   = ST_SQ;
            end
            default: begin
                // plain text, also covers unused codes
                result.count = plain_emit ? 2'd1 : 2'd0;
                state_next   = plain_state;
                dir_next     = plain_dir;
            end
        endcase

        // End of text: flush a held slash, mark the final word, restart
        if (end_of_text) begin
            if (state_next == ST_SLASH) begin
                result.count = 2'd1;
                result.ch0   = CH_SLASH;
            end
            result.last0 = (result.count == 2'd1);
            result.last1 = (result.count == 2'd2);
            state_next   = ST_NORMAL;
            dir_next     = 1'b0;
        end
    end

    // Hold lexer state, advance on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_NORMAL;
            dir_reg   <= 1'b0;
        end else if (step) begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/c_comment_stripper.sv @@
// A byte's words are registered into the output queue when it is accepted.
// Throughput: one byte per cycle unless the queue lacks room for two words; a
// byte that yields two words (a late slash plus the byte) is absorbed by a 4-word queue.
// Input is taken whenever the queue has room for two words.
// Reset (aresetn, synchronous, active low) returns the lexer to plain text,
// clears the directive flag and empties the output queue.
// ----------------------------------------------------------------------------
// c_comment_stripper
// Removes C and C++ comments from a byte stream. The lexer decides each byte
// combinationally and pushes up to two result words into a small output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_ch,
    output logic            m_out_last
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ccs_step_t step_res;
    logic      s_fire;
    logic      m_fire;

    logic [7:0]    q_ch_reg   [DEPTH];
    logic          q_last_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_plus1;

    // Accept while two free slots remain
    assign s_ready = (count_reg <= CW'(DEPTH - 2));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid && m_ready;

    assign m_out_ch   = q_ch_reg[rd_ptr_reg];
    assign m_out_last = q_last_reg[rd_ptr_reg];

    ccs_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_fire),
        .ch          (s_ch),
        .end_of_text (s_end_of_text),
        .result      (step_res)
    );

    // Pointer and fill arithmetic, wrapping at DEPTH
    always_comb begin
        wr_ptr_plus1 = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg;
        if (s_fire && step_res.count == 2'd1) begin
            wr_ptr_next = wr_ptr_plus1;
        end else if (s_fire && step_res.count == 2'd2) begin
            wr_ptr_next = (wr_ptr_plus1 == PW'(DEPTH - 1)) ? '0 : wr_ptr_plus1 + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (m_fire) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg
                   + (s_fire ? CW'(step_res.count) : CW'(0))
                   - (m_fire ? CW'(1) : CW'(0));
    end

    // Hold queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write result words into the queue
    always_ff @(posedge aclk) begin
        if (s_fire && step_res.count != 2'd0) begin
            q_ch_reg[wr_ptr_reg]   <= step_res.ch0;
            q_last_reg[wr_ptr_reg] <= step_res.last0;
        end
        if (s_fire && step_res.count == 2'd2) begin
            q_ch_reg[wr_ptr_plus1]   <= step_res.ch1;
            q_last_reg[wr_ptr_plus1] <= step_res.last1;
        end
    end

endmodule

`default_nettype wire
